// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
// both macros sample on i_clk and are disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define IPF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ipf assertion failed");

// next-cycle implication
`define IPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ipf assertion failed");

`endif

// ===== rtl/ipf_pkg.sv =====
`default_nettype none
package ipf_pkg;

    localparam int VER_W     = 8;
    localparam int ADDR_W    = 128;
    localparam int HALF_W    = 64;
    localparam int V4_W      = 32;
    localparam int CHAR_W    = 7;
    localparam int NIB_W     = 4;
    localparam int WORD_W    = 16;
    localparam int NUM_WORDS = 8;
    localparam int BYTE_W    = 8;

    // version codes
    localparam logic [VER_W-1:0] VER_V6 = 8'd6;
    localparam logic [VER_W-1:0] VER_V4 = 8'd4;

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2e;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3a;

    localparam logic [CHAR_W-1:0] HEX_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef struct packed {
        logic [VER_W-1:0]  version;
        logic [HALF_W-1:0] ipv6_high;
        logic [HALF_W-1:0] ipv6_low;
        logic [V4_W-1:0]   ipv4_word;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
        logic              empty_text;
    } t_out_item;

    // one character offered by the sequencer to the output stage
    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_emit;

    typedef struct packed {
        logic [1:0] h;
        logic [3:0] t;
        logic [3:0] o;
    } t_dec;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
        return HEX_CHARS[nib];
    endfunction

    // decimal digits of one byte by compare and subtract
    function automatic t_dec dec_split(input logic [BYTE_W-1:0] b);
        t_dec              d;
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] tens;
        if (b >= 8'd200) begin
            d.h = 2'd2;
            r   = b - 8'd200;
        end else if (b >= 8'd100) begin
            d.h = 2'd1;
            r   = b - 8'd100;
        end else begin
            d.h = 2'd0;
            r   = b;
        end
        d.t = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (r >= 8'(10 * k)) begin
                d.t = 4'(k);
            end
        end
        tens = ({4'd0, d.t} << 3) + ({4'd0, d.t} << 1);
        d.o  = 4'(r - tens);
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ipf_stream_if.sv =====
`default_nettype none
interface ipf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ip_address_text_formatter_core.sv =====
// IP address text formatter. Each input transfer carries a version code and an
// address; the block returns the address text as a stream of 7-bit ASCII
// characters, one per output transfer, with last_char marking the final one.
// Version 6 gives eight lowercase hex words without leading zeros joined by
// colons, with the first run of zero words (a lone zero word too) written as
// "::". Version 4 gives dotted decimal without leading zeros. Any other
// version gives a single transfer with empty_text and last_char set and a
// zero character. One address is worked on at a time: input ready is high
// only while the sequencer is idle. An address holds the sequencer for a
// load step plus its stepping slots: IPv6 takes five slots per word, a
// separator slot and four nibble slots, as the address shift register moves
// one hex digit per cycle while the output is not stalled, and one more slot
// when "::" stands at the start or in the middle; a zero run that reaches the
// last word ends the text at the second colon; IPv4 takes four slots per byte
// (dot, hundreds, tens, ones); an unsupported version takes only the S_EMPTY
// slot after the load. Output stalls hold the sequencer in its slot. The output
// register lets the next address load while the last character of the previous
// one still waits to be taken.
`default_nettype none
module ip_address_text_formatter_core
    import ipf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    ipf_stream_if.sink   i_in,
    ipf_stream_if.source o_out
);

    // character offered by the sequencer, and the output stage's go signal
    t_emit w_emit;
    logic  w_adv;

    // digit-serial sequencer: address shift register and formatting control
    ipf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (w_adv),
        .o_emit  (w_emit)
    );

    // output register parting the sequencer from the downstream ready
    ipf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );

`include "assert_macros.svh"

    // after the final character the sequencer is free for the next address
    `IPF_ASSERT_NEXT(a_last_frees_seq, w_emit.valid && w_emit.item.last_char, i_in.ready)

    // the cycle after a load offers at most a leading colon or the empty marker
    `IPF_ASSERT_NEXT(a_no_char_after_load, i_in.valid && i_in.ready,
                     !w_emit.valid || w_emit.item.empty_text || (w_emit.item.text_char == CHAR_COLON))

    // an empty result is a single zero character
    `IPF_ASSERT_NOW(a_empty_shape, o_out.valid && o_out.data.empty_text,
                    o_out.data.last_char && (o_out.data.text_char == CHAR_NUL))

    // text characters are dot, colon, digits or lowercase hex letters; checked as none below dot
    `IPF_ASSERT_NOW(a_char_range, o_out.valid && !o_out.data.empty_text,
                    o_out.data.text_char >= CHAR_DOT)

endmodule
`default_nettype wire

// ===== rtl/ipf_seq.sv =====
`default_nettype none
module ipf_seq
    import ipf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ipf_stream_if.sink i_in,
    input  wire logic  i_adv,
    output t_emit      o_emit
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMPTY,
        S_V6_SEP,
        S_V6_COL2,
        S_V6_NIB,
        S_V6_SKIP,
        S_V4_SEP,
        S_V4_H,
        S_V4_T,
        S_V4_O
    } t_state;

    t_state                 r_state, n_state;
    logic [ADDR_W-1:0]      r_sh, n_sh;
    logic [NUM_WORDS-1:0]   r_zf, n_zf;
    logic [2:0]             r_wcnt, n_wcnt;
    logic [1:0]             r_nib, n_nib;
    logic                   r_lead, n_lead;
    logic                   r_in_run, n_in_run;
    logic                   r_run_done, n_run_done;

    logic [ADDR_W-1:0]      w_addr;
    logic [NIB_W-1:0]       w_digit;
    t_dec                   w_dec;
    logic [BYTE_W-1:0]      w_byte;

    assign w_addr  = {i_in.data.ipv6_high, i_in.data.ipv6_low};
    assign w_digit = r_sh[ADDR_W-1 -: NIB_W];
    assign w_byte  = r_sh[ADDR_W-1 -: BYTE_W];
    assign w_dec   = dec_split(w_byte);

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_sh       = r_sh;
        n_zf       = r_zf;
        n_wcnt     = r_wcnt;
        n_nib      = r_nib;
        n_lead     = r_lead;
        n_in_run   = r_in_run;
        n_run_done = r_run_done;
        o_emit     = '{valid: 1'b0, item: '{text_char: CHAR_NUL, last_char: 1'b0,
                                            empty_text: 1'b0}};
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_wcnt     = 3'd0;
                    n_nib      = 2'd0;
                    n_lead     = 1'b1;
                    n_in_run   = 1'b0;
                    n_run_done = 1'b0;
                    for (int i = 0; i < NUM_WORDS; i++) begin
                        n_zf[NUM_WORDS-1-i] = (w_addr[ADDR_W-1-WORD_W*i -: WORD_W] == '0);
                    end
                    if (i_in.data.version == VER_V6) begin
                        n_sh    = w_addr;
                        n_state = S_V6_SEP;
                    end else if (i_in.data.version == VER_V4) begin
                        n_sh    = {i_in.data.ipv4_word, {(ADDR_W-V4_W){1'b0}}};
                        n_state = S_V4_SEP;
                    end else begin
                        n_state = S_EMPTY;
                    end
                end
            end
            S_EMPTY: begin
                if (i_adv) begin
                    o_emit.valid           = 1'b1;
                    o_emit.item.last_char  = 1'b1;
                    o_emit.item.empty_text = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            S_V6_SEP: begin
                if (i_adv) begin
                    n_nib  = 2'd0;
                    n_lead = 1'b1;
                    if (r_in_run) begin
                        if (r_zf[NUM_WORDS-1]) begin
                            n_state = S_V6_SKIP;
                        end else begin
                            // run closed: this word follows "::" with no colon
                            n_in_run   = 1'b0;
                            n_run_done = 1'b1;
                            n_state    = S_V6_NIB;
                        end
                    end else if (r_zf[NUM_WORDS-1] && !r_run_done) begin
                        o_emit.valid          = 1'b1;
                        o_emit.item.text_char = CHAR_COLON;
                        n_state               = S_V6_COL2;
                    end else begin
                        if (r_wcnt != 3'd0) begin
                            o_emit.valid          = 1'b1;
                            o_emit.item.text_char = CHAR_COLON;
                        end
                        n_state = S_V6_NIB;
                    end
                end
            end
            S_V6_COL2: begin
                if (i_adv) begin
                    o_emit.valid          = 1'b1;
                    o_emit.item.text_char = CHAR_COLON;
                    // trailing run: nothing but zero words left
                    if (&r_zf) begin
                        o_emit.item.last_char = 1'b1;
                        n_state               = S_IDLE;
                    end else begin
                        n_in_run = 1'b1;
                        n_state  = S_V6_SKIP;
                    end
                end
            end
            S_V6_NIB, S_V6_SKIP: begin
                if (i_adv) begin
                    if (r_state == S_V6_NIB &&
                        (w_digit != '0 || !r_lead || r_nib == 2'd3)) begin
                        o_emit.valid          = 1'b1;
                        o_emit.item.text_char = hex_char(w_digit);
                        o_emit.item.last_char = (r_nib == 2'd3) && (r_wcnt == 3'd7);
                    end
                    n_lead = r_lead && (w_digit == '0);
                    n_sh   = {r_sh[ADDR_W-NIB_W-1:0], {NIB_W{1'b0}}};
                    n_nib  = r_nib + 2'd1;
                    if (r_nib == 2'd3) begin
                        n_zf   = {r_zf[NUM_WORDS-2:0], 1'b1};
                        n_wcnt = r_wcnt + 3'd1;
                        n_state = (r_wcnt == 3'd7) ? S_IDLE : S_V6_SEP;
                    end
                end
            end
            S_V4_SEP: begin
                if (i_adv) begin
                    if (r_wcnt != 3'd0) begin
                        o_emit.valid          = 1'b1;
                        o_emit.item.text_char = CHAR_DOT;
                    end
                    n_state = S_V4_H;
                end
            end
            S_V4_H: begin
                if (i_adv) begin
                    if (w_byte >= 8'd100) begin
                        o_emit.valid          = 1'b1;
                        o_emit.item.text_char = CHAR_ZERO + {5'd0, w_dec.h};
                    end
                    n_state = S_V4_T;
                end
            end
            S_V4_T: begin
                if (i_adv) begin
                    if (w_byte >= 8'd10) begin
                        o_emit.valid          = 1'b1;
                        o_emit.item.text_char = CHAR_ZERO + {3'd0, w_dec.t};
                    end
                    n_state = S_V4_O;
                end
            end
            S_V4_O: begin
                if (i_adv) begin
                    o_emit.valid          = 1'b1;
                    o_emit.item.text_char = CHAR_ZERO + {3'd0, w_dec.o};
                    o_emit.item.last_char = (r_wcnt == 3'd3);
                    n_sh   = {r_sh[ADDR_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                    n_wcnt = r_wcnt + 3'd1;
                    n_state = (r_wcnt == 3'd3) ? S_IDLE : S_V4_SEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sh   <= n_sh;
        r_zf   <= n_zf;
        r_wcnt <= n_wcnt;
        r_nib  <= n_nib;
        r_lead <= n_lead;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_run   <= 1'b0;
            r_run_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_run   <= n_in_run;
            r_run_done <= n_run_done;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ipf_out_reg.sv =====
`default_nettype none
module ipf_out_reg
    import ipf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  t_emit        i_emit,
    output logic         o_adv,
    ipf_stream_if.source o_out
);

    logic      r_valid;
    t_out_item r_item;

    // register can take a new character when empty or being drained
    assign o_adv       = !r_valid || o_out.ready;
    assign o_out.valid = r_valid;
    assign o_out.data  = r_item;

    always_ff @(posedge i_clk) begin
        if (o_adv && i_emit.valid) begin
            r_item <= i_emit.item;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_emit.valid;
        end
    end

endmodule
`default_nettype wire
